// File: rtl/lzw_byte_encoder_macros.svh
// Assertion macros for the LZW byte encoder.
`ifndef LZW_BYTE_ENCODER_MACROS_SVH
`define LZW_BYTE_ENCODER_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define LZW_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define LZW_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// File: rtl/lzw_pkg.sv
// Package: types, constants and command codes for the LZW byte encoder.
package lzw_pkg;
	localparam int DictSizeDefault = 4096;
	localparam logic [7:0] CodeBytes = 8'd2;
	localparam int FirstFree = 256;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       is_last;
	} lzw_in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_end;
		logic       stream_end;
		logic       dict_full;
	} lzw_out_t;

	// output byte source select
	localparam logic [1:0] SelHeader = 2'd0;
	localparam logic [1:0] SelHi     = 2'd1;
	localparam logic [1:0] SelLo     = 2'd2;

	typedef struct packed {
		logic       load;      // capture input item
		logic       probe_rd;  // issue dictionary read at probe address
		logic       probe_inc; // advance probe address
		logic       take_hit;  // prefix <= probe address
		logic       take_byte; // prefix <= byte, prefix_valid <= 1
		logic       insert;    // write (prefix, byte) at next_code if room
		logic       emit;      // push one output byte
		logic [1:0] emit_sel;
		logic       emit_run_end;
		logic       emit_stream_end;
		logic       set_header;
		logic       restart;   // return to stream start
	} lzw_cmd_t;

	typedef struct packed {
		logic header_sent;
		logic prefix_valid;
		logic is_last;
		logic probe_done;  // probe address reached next_code or limit
		logic probe_match; // registered read data matches
		logic out_busy;    // output register full and not draining
	} lzw_sts_t;
endpackage

// File: rtl/lzw_byte_encoder.sv
// Top level: LZW byte encoder, controller plus datapath.
//  channel | direction | payload
//  in      | input     | in_byte, is_last
//  out     | output    | out_byte, run_end, stream_end, dict_full
// Each item passes Idle, Head and Start; with a valid prefix it then searches the learned
// codes linearly in Read and Check, inserts on a miss and emits the code bytes, or ends in
// Done if it emits no code; the header adds no extra state. The dictionary read is registered.
// Reset clears prefix, code counter and header flag; the dictionary needs no clearing.
// A stalled output holds the controller at its next emit.
module lzw_byte_encoder import lzw_pkg::*; #(
	parameter int DICT_SIZE = DictSizeDefault
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  lzw_in_t  in_item,
	output logic     out_valid,
	input  logic     out_ready,
	output lzw_out_t out_item
);
	lzw_cmd_t cmd;
	lzw_sts_t sts;

	lzw_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.sts(sts), .cmd(cmd)
	);

	lzw_datapath #(.DICT_SIZE(DICT_SIZE)) u_dp (
		.clk(clk), .arst_n(arst_n), .in_item(in_item), .cmd(cmd), .sts(sts),
		.out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
	);
endmodule

// File: rtl/lzw_datapath.sv
// Datapath: input capture, prefix and code registers, dictionary memory, output register.
module lzw_datapath import lzw_pkg::*; #(
	parameter int DICT_SIZE = DictSizeDefault
) (
	input  logic     clk,
	input  logic     arst_n,
	input  lzw_in_t  in_item,
	input  lzw_cmd_t cmd,
	output lzw_sts_t sts,
	output logic     out_valid,
	input  logic     out_ready,
	output lzw_out_t out_item
);
	`include "lzw_byte_encoder_macros.svh"

	localparam int CW = $clog2(DICT_SIZE + 1);
	localparam int AW = $clog2(DICT_SIZE);
	localparam logic [CW-1:0] First = CW'(FirstFree);
	localparam logic [CW-1:0] Limit = CW'(DICT_SIZE);

	logic [AW-1:0] mem_prefix [DICT_SIZE];
	logic [7:0]    mem_byte   [DICT_SIZE];

	logic [7:0]    byte_q;
	logic          last_q;
	logic [AW-1:0] prefix_q;
	logic          prefix_valid_q;
	logic          header_q;
	logic [CW-1:0] next_q;
	logic [CW-1:0] probe_q;
	logic [AW-1:0] rd_prefix_q;
	logic [7:0]    rd_byte_q;
	logic          rd_valid_q;
	logic          ov_q;
	lzw_out_t      out_q;
	logic          full;
	logic [15:0]   code16;
	logic [7:0]    emit_byte;

	assign full   = (next_q >= Limit);
	assign code16 = 16'(prefix_q);

	always_comb begin
		case (cmd.emit_sel)
			SelHeader: emit_byte = CodeBytes;
			SelHi:     emit_byte = code16[15:8];
			default:   emit_byte = code16[7:0];
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.insert && !full) begin
			mem_prefix[next_q[AW-1:0]] <= prefix_q;
			mem_byte[next_q[AW-1:0]]   <= byte_q;
		end
		if (cmd.probe_rd) begin
			rd_prefix_q <= mem_prefix[probe_q[AW-1:0]];
			rd_byte_q   <= mem_byte[probe_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			byte_q <= in_item.in_byte;
			last_q <= in_item.is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prefix_q       <= '0;
			prefix_valid_q <= 1'b0;
			header_q       <= 1'b0;
			next_q         <= First;
			probe_q        <= First;
			rd_valid_q     <= 1'b0;
			ov_q           <= 1'b0;
			out_q          <= '0;
		end else begin
			rd_valid_q <= cmd.probe_rd;
			if (cmd.load)
				probe_q <= First;
			else if (cmd.probe_inc)
				probe_q <= probe_q + CW'(1);
			if (cmd.set_header)
				header_q <= 1'b1;
			if (cmd.take_hit)
				prefix_q <= probe_q[AW-1:0];
			if (cmd.take_byte) begin
				prefix_q       <= AW'(byte_q);
				prefix_valid_q <= 1'b1;
			end
			if (cmd.insert && !full)
				next_q <= next_q + CW'(1);
			if (cmd.emit) begin
				ov_q                <= 1'b1;
				out_q.out_byte      <= emit_byte;
				out_q.run_end       <= cmd.emit_run_end;
				out_q.stream_end    <= cmd.emit_stream_end;
				out_q.dict_full     <= full;
			end else if (out_ready)
				ov_q <= 1'b0;
			if (cmd.restart) begin
				prefix_q       <= '0;
				prefix_valid_q <= 1'b0;
				header_q       <= 1'b0;
				next_q         <= First;
			end
		end
	end

	assign sts.header_sent  = header_q;
	assign sts.prefix_valid = prefix_valid_q;
	assign sts.is_last      = last_q;
	assign sts.probe_done   = (probe_q >= next_q) || (probe_q >= Limit);
	assign sts.probe_match  = rd_valid_q && (rd_prefix_q == prefix_q) && (rd_byte_q == byte_q);
	assign sts.out_busy     = ov_q && !out_ready;

	assign out_valid = ov_q;
	assign out_item  = out_q;

	`LZW_ASSERT_IMP(a_no_emit_busy, cmd.emit, !(ov_q && !out_ready), "emit over pending item")
	`LZW_ASSERT_IMP(a_next_range, 1'b1, next_q >= First && next_q <= Limit, "next code range")
	`LZW_ASSERT_NEXT(a_restart, cmd.restart, next_q == First && !prefix_valid_q, "restart failed")
endmodule

// File: rtl/lzw_ctrl.sv
// Controller: sequences header, dictionary probe, insert and code emission per item.
module lzw_ctrl import lzw_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  lzw_sts_t sts,
	output lzw_cmd_t cmd
);
	`include "lzw_byte_encoder_macros.svh"

	localparam logic [3:0] StIdle   = 4'd0;
	localparam logic [3:0] StHead   = 4'd1;
	localparam logic [3:0] StStart  = 4'd2;
	localparam logic [3:0] StRead   = 4'd3;
	localparam logic [3:0] StCheck  = 4'd4;
	localparam logic [3:0] StMissHi = 4'd5;
	localparam logic [3:0] StMissLo = 4'd6;
	localparam logic [3:0] StFlHi   = 4'd7;
	localparam logic [3:0] StFlLo   = 4'd8;
	localparam logic [3:0] StDone   = 4'd9;

	logic [3:0] state_q, state_d;

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		in_ready = 1'b0;
		unique case (state_q)
			StIdle: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = StHead;
				end
			end
			StHead: begin
				if (!sts.header_sent) begin
					if (!sts.out_busy) begin
						cmd.emit = 1'b1;
						cmd.emit_sel = SelHeader;
						// first byte of a stream that is not last: header ends the run
						cmd.emit_run_end = !sts.is_last;
						cmd.set_header = 1'b1;
						state_d = StStart;
					end
				end else
					state_d = StStart;
			end
			StStart: begin
				if (!sts.prefix_valid) begin
					cmd.take_byte = 1'b1;
					state_d = sts.is_last ? StFlHi : StDone;
				end else
					state_d = StRead;
			end
			StRead: begin
				if (sts.probe_done) begin
					// miss: insert first so every code byte carries the new full flag
					cmd.insert = 1'b1;
					state_d = StMissHi;
				end else begin
					cmd.probe_rd = 1'b1;
					state_d = StCheck;
				end
			end
			StCheck: begin
				if (sts.probe_match) begin
					cmd.take_hit = 1'b1;
					state_d = sts.is_last ? StFlHi : StDone;
				end else begin
					cmd.probe_inc = 1'b1;
					state_d = StRead;
				end
			end
			StMissHi: begin
				if (!sts.out_busy) begin
					cmd.emit = 1'b1;
					cmd.emit_sel = SelHi;
					state_d = StMissLo;
				end
			end
			StMissLo: begin
				if (!sts.out_busy) begin
					cmd.emit = 1'b1;
					cmd.emit_sel = SelLo;
					cmd.emit_run_end = !sts.is_last;
					cmd.take_byte = 1'b1;
					state_d = sts.is_last ? StFlHi : StIdle;
				end
			end
			StFlHi: begin
				if (!sts.out_busy) begin
					cmd.emit = 1'b1;
					cmd.emit_sel = SelHi;
					state_d = StFlLo;
				end
			end
			StFlLo: begin
				if (!sts.out_busy) begin
					cmd.emit = 1'b1;
					cmd.emit_sel = SelLo;
					cmd.emit_run_end = 1'b1;
					cmd.emit_stream_end = 1'b1;
					cmd.restart = 1'b1;
					state_d = StIdle;
				end
			end
			StDone: begin
				// item emits no code
				state_d = StIdle;
			end
			default: state_d = StIdle;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= StIdle;
		else
			state_q <= state_d;
	end

	`LZW_ASSERT_IMP(a_ready_idle, in_ready, state_q == StIdle, "ready outside idle")
	`LZW_ASSERT_IMP(a_one_src, 1'b1, !(cmd.take_hit && cmd.take_byte), "two prefix sources")
	`LZW_ASSERT_NEXT(a_load_head, cmd.load, state_q == StHead, "load did not start item")
endmodule
